[design/rtad_pkg.sv]
`default_nettype none

package rtad_pkg;

    // Table depth used when the top level is not given another value.
    localparam int unsigned REGION_COUNT_DEF = 16;

    // Fixed field widths of the item and result channels.
    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned BYTES_W  = 4;
    localparam int unsigned DATA_W   = 64;
    localparam int unsigned TAG_W    = 5;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned INDEX_W  = 4;

    // Operation codes carried by the opcode field.
    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_READ  = 2'd2,
        OP_WRITE = 2'd3
    } t_opcode;

    // Status codes returned with every result.
    typedef enum logic [STATUS_W-1:0] {
        ST_HIT     = 3'd0,
        ST_MISS    = 3'd1,
        ST_ADDED   = 3'd2,
        ST_FULL    = 3'd3,
        ST_CLEARED = 3'd4
    } t_status;

    // One stored region.
    typedef struct packed {
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] last;
        logic [ADDR_W-1:0] cmp_mask;
        logic [ADDR_W-1:0] offset_mask;
        logic [TAG_W-1:0]  tag;
    } t_region;

    // Outcome of comparing one access against one region.
    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] device_addr;
    } t_match;

    // One result item.
    typedef struct packed {
        t_status            status;
        logic [INDEX_W-1:0] region_index;
        logic [TAG_W-1:0]   region_tag;
        logic [ADDR_W-1:0]  device_addr;
        logic               is_write;
        logic [DATA_W-1:0]  data_out;
    } t_result;

endpackage

`default_nettype wire

[design/rtad_if.sv]
`default_nettype none

// Item channel: one operation with all of its operand fields.
interface rtad_in_if;
    logic                             valid;
    logic                             ready;
    logic [rtad_pkg::OPCODE_W-1:0]    opcode;
    logic [rtad_pkg::ADDR_W-1:0]      access_addr;
    logic [rtad_pkg::BYTES_W-1:0]     access_bytes;
    logic [rtad_pkg::DATA_W-1:0]      write_data;
    logic [rtad_pkg::ADDR_W-1:0]      new_first;
    logic [rtad_pkg::ADDR_W-1:0]      new_last;
    logic [rtad_pkg::ADDR_W-1:0]      new_range_mask;
    logic [rtad_pkg::ADDR_W-1:0]      new_offset_mask;
    logic [rtad_pkg::TAG_W-1:0]       new_tag;

    modport source (
        output valid, opcode, access_addr, access_bytes, write_data,
        output new_first, new_last, new_range_mask, new_offset_mask, new_tag,
        input  ready
    );

    modport sink (
        input  valid, opcode, access_addr, access_bytes, write_data,
        input  new_first, new_last, new_range_mask, new_offset_mask, new_tag,
        output ready
    );
endinterface

// Result channel: status and decode outcome of one operation.
interface rtad_out_if;
    logic                             valid;
    logic                             ready;
    logic [rtad_pkg::STATUS_W-1:0]    status;
    logic [rtad_pkg::INDEX_W-1:0]     region_index;
    logic [rtad_pkg::TAG_W-1:0]       region_tag;
    logic [rtad_pkg::ADDR_W-1:0]      device_addr;
    logic                             is_write;
    logic [rtad_pkg::DATA_W-1:0]      data_out;

    modport source (
        output valid, status, region_index, region_tag, device_addr, is_write,
        output data_out,
        input  ready
    );

    modport sink (
        input  valid, status, region_index, region_tag, device_addr, is_write,
        input  data_out,
        output ready
    );
endinterface

`default_nettype wire

[design/region_table_address_decoder.sv]
`default_nettype none

// Region table address decoder. Holds up to REGION_COUNT address regions and
// handles one item at a time: clear, add a region, or decode a read or write
// access. Each result moves from the result register to the output register
// once that is free; clear and add go there directly, while an access first
// scans the table, which sits in a memory with one read port, comparing the
// regions one per cycle, lowest index first, until the first one that matches.
// Input ready is high only while no item is in work and comes back as the
// result enters the output register, so a new item is taken while a result
// still waits in the output register. Table entries are not cleared at reset:
// the table count starts at zero.
module region_table_address_decoder #(
    parameter int unsigned REGION_COUNT = rtad_pkg::REGION_COUNT_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    rtad_in_if.sink         i_in,
    rtad_out_if.source      o_out
);

    localparam int unsigned IDX_W = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
    localparam int unsigned CNT_W = $clog2(REGION_COUNT + 1);
    localparam int unsigned OUT_IDX_W = rtad_pkg::INDEX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                         r_state, n_state;
    logic [CNT_W-1:0]               r_count, n_count;
    logic                           r_is_write, n_is_write;
    logic [rtad_pkg::ADDR_W-1:0]    r_addr, n_addr;
    logic [rtad_pkg::ADDR_W-1:0]    r_last_byte, n_last_byte;
    logic [rtad_pkg::DATA_W-1:0]    r_wdata, n_wdata;
    logic [CNT_W-1:0]               r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]               r_chk_idx, n_chk_idx;
    logic                           r_chk_vld, n_chk_vld;
    rtad_pkg::t_result              r_res, n_res;
    rtad_pkg::t_result              r_out, n_out;
    logic                           r_out_valid, n_out_valid;

    logic                           in_xfer;
    logic                           table_full;
    logic                           mem_wr_en;
    rtad_pkg::t_region              mem_wr_data;
    rtad_pkg::t_region              mem_rd_data;
    rtad_pkg::t_match               match;

    assign in_xfer    = i_in.valid && i_in.ready;
    assign table_full = (r_count >= CNT_W'(REGION_COUNT));

    // A new region is written into the next free slot at the add transfer.
    assign mem_wr_en = in_xfer && (i_in.opcode == rtad_pkg::OP_ADD) && !table_full;
    assign mem_wr_data.first       = i_in.new_first;
    assign mem_wr_data.last        = i_in.new_last;
    assign mem_wr_data.cmp_mask    = i_in.new_range_mask;
    assign mem_wr_data.offset_mask = i_in.new_offset_mask;
    assign mem_wr_data.tag         = i_in.new_tag;

    rtad_region_mem #(
        .REGION_COUNT (REGION_COUNT),
        .IDX_W        (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (r_rd_idx[IDX_W-1:0]),
        .o_rd_data (mem_rd_data)
    );

    rtad_match u_match (
        .i_region    (mem_rd_data),
        .i_start     (r_addr),
        .i_last_byte (r_last_byte),
        .o_match     (match)
    );

    // Sequencer: take an item, scan the table for accesses, hand off the result.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_is_write  = r_is_write;
        n_addr      = r_addr;
        n_last_byte = r_last_byte;
        n_wdata     = r_wdata;
        n_rd_idx    = r_rd_idx;
        n_chk_idx   = r_chk_idx;
        n_chk_vld   = 1'b0;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_res = '0;
                    case (i_in.opcode)
                        rtad_pkg::OP_CLEAR: begin
                            n_count      = '0;
                            n_res.status = rtad_pkg::ST_CLEARED;
                            n_state      = S_DONE;
                        end
                        rtad_pkg::OP_ADD: begin
                            if (table_full) begin
                                n_res.status = rtad_pkg::ST_FULL;
                            end else begin
                                n_res.status       = rtad_pkg::ST_ADDED;
                                n_res.region_index = OUT_IDX_W'(r_count);
                                n_count            = r_count + CNT_W'(1);
                            end
                            n_state = S_DONE;
                        end
                        default: begin
                            // Read or write access: the last byte wraps at 32 bits.
                            n_is_write  = (i_in.opcode == rtad_pkg::OP_WRITE);
                            n_addr      = i_in.access_addr;
                            n_last_byte = i_in.access_addr
                                          + rtad_pkg::ADDR_W'(i_in.access_bytes)
                                          - rtad_pkg::ADDR_W'(1);
                            n_wdata     = i_in.write_data;
                            n_rd_idx    = '0;
                            n_state     = S_SCAN;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Read address runs one entry ahead of the compare.
                if (r_rd_idx < r_count) begin
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_rd_idx[IDX_W-1:0];
                    n_rd_idx  = r_rd_idx + CNT_W'(1);
                end
                if (r_chk_vld && match.hit) begin
                    n_chk_vld          = 1'b0;
                    n_res              = '0;
                    n_res.status       = rtad_pkg::ST_HIT;
                    n_res.region_index = OUT_IDX_W'(r_chk_idx);
                    n_res.region_tag   = mem_rd_data.tag;
                    n_res.device_addr  = match.device_addr;
                    n_res.is_write     = r_is_write;
                    n_res.data_out     = r_is_write ? r_wdata : '0;
                    n_state            = S_DONE;
                end else if (r_rd_idx >= r_count) begin
                    // Every stored region has been checked without a match.
                    n_chk_vld      = 1'b0;
                    n_res          = '0;
                    n_res.status   = rtad_pkg::ST_MISS;
                    n_res.is_write = r_is_write;
                    n_state        = S_DONE;
                end
            end

            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_chk_vld   <= n_chk_vld;
            r_out_valid <= n_out_valid;
        end
        r_is_write  <= n_is_write;
        r_addr      <= n_addr;
        r_last_byte <= n_last_byte;
        r_wdata     <= n_wdata;
        r_rd_idx    <= n_rd_idx;
        r_chk_idx   <= n_chk_idx;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    assign i_in.ready = (r_state == S_IDLE);

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out.status;
    assign o_out.region_index = r_out.region_index;
    assign o_out.region_tag   = r_out.region_tag;
    assign o_out.device_addr  = r_out.device_addr;
    assign o_out.is_write     = r_out.is_write;
    assign o_out.data_out     = r_out.data_out;

endmodule

`default_nettype wire

[design/rtad_region_mem.sv]
`default_nettype none

// Region storage: one write port, one read port with registered read data.
module rtad_region_mem #(
    parameter int unsigned REGION_COUNT = rtad_pkg::REGION_COUNT_DEF,
    parameter int unsigned IDX_W        = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_wr_en,
    input  wire logic [IDX_W-1:0]     i_wr_addr,
    input  wire rtad_pkg::t_region    i_wr_data,
    input  wire logic [IDX_W-1:0]     i_rd_addr,
    output rtad_pkg::t_region         o_rd_data
);

    rtad_pkg::t_region r_mem [REGION_COUNT];
    rtad_pkg::t_region r_rd_data;

    // Entries hold no reset value; only written entries are ever compared.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[design/rtad_match.sv]
`default_nettype none

// Compare unit shared by every step of the scan: one region against one access.
module rtad_match (
    input  wire rtad_pkg::t_region              i_region,
    input  wire logic [rtad_pkg::ADDR_W-1:0]    i_start,
    input  wire logic [rtad_pkg::ADDR_W-1:0]    i_last_byte,
    output rtad_pkg::t_match                    o_match
);

    logic [rtad_pkg::ADDR_W-1:0] start_masked;
    logic [rtad_pkg::ADDR_W-1:0] last_masked;

    // Both ends of the access are masked before the bounds check.
    assign start_masked = i_start & i_region.cmp_mask;
    assign last_masked  = i_last_byte & i_region.cmp_mask;

    assign o_match.hit = (start_masked >= i_region.first) &&
                         (last_masked <= i_region.last);
    assign o_match.device_addr = i_start & i_region.offset_mask;

endmodule

`default_nettype wire

[verif/tb_region_table_address_decoder.sv]
`default_nettype none

module tb_region_table_address_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import rtad_pkg::*;

    localparam int unsigned NUM_REGIONS = REGION_COUNT_DEF;
    localparam int unsigned CLK_PERIOD  = 10;
    localparam int unsigned RST_CYCLES  = 11;
    localparam int unsigned PHASE_ITEMS = 500;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned MAX_REPORTS = 10;

    // One operation as it is offered on the item channel.
    typedef struct packed {
        t_opcode            op;
        logic [ADDR_W-1:0]  addr;
        logic [BYTES_W-1:0] nbytes;
        logic [DATA_W-1:0]  wdata;
        logic [ADDR_W-1:0]  rgn_lo;
        logic [ADDR_W-1:0]  rgn_hi;
        logic [ADDR_W-1:0]  rmask;
        logic [ADDR_W-1:0]  omask;
        logic [TAG_W-1:0]   tag;
    } t_item;

    // Mirror of the region table that predicts every decode, and the results
    // still owed by the block in transfer order.
    class decode_scoreboard;
        t_result            owed_results[$];
        logic [ADDR_W-1:0]  rgn_lo    [NUM_REGIONS];
        logic [ADDR_W-1:0]  rgn_hi    [NUM_REGIONS];
        logic [ADDR_W-1:0]  rgn_rmask [NUM_REGIONS];
        logic [ADDR_W-1:0]  rgn_omask [NUM_REGIONS];
        logic [TAG_W-1:0]   rgn_tag   [NUM_REGIONS];
        int unsigned        rgn_used;
        int unsigned        result_count;
        int unsigned        error_count;

        // Work out the result of one operation and update the mirrored table.
        function t_result decode_item(t_item it);
            t_result           r;
            logic [ADDR_W-1:0] last_byte;
            logic [ADDR_W-1:0] rm;
            bit                found;
            r = '0;
            case (it.op)
                OP_CLEAR: begin
                    rgn_used = 0;
                    r.status = ST_CLEARED;
                end
                OP_ADD: begin
                    if (rgn_used >= NUM_REGIONS) begin
                        r.status = ST_FULL;
                    end else begin
                        rgn_lo[rgn_used]    = it.rgn_lo;
                        rgn_hi[rgn_used]    = it.rgn_hi;
                        rgn_rmask[rgn_used] = it.rmask;
                        rgn_omask[rgn_used] = it.omask;
                        rgn_tag[rgn_used]   = it.tag;
                        r.status            = ST_ADDED;
                        r.region_index      = INDEX_W'(rgn_used);
                        rgn_used++;
                    end
                end
                default: begin
                    // Lowest index whose masked range holds both end bytes wins.
                    r.is_write = (it.op == OP_WRITE);
                    r.status   = ST_MISS;
                    last_byte  = it.addr + ADDR_W'(it.nbytes) - ADDR_W'(1);
                    found      = 1'b0;
                    for (int i = 0; i < int'(rgn_used) && !found; i++) begin
                        rm = rgn_rmask[i];
                        if ((it.addr & rm) >= rgn_lo[i] && (last_byte & rm) <= rgn_hi[i]) begin
                            found          = 1'b1;
                            r.status       = ST_HIT;
                            r.region_index = INDEX_W'(i);
                            r.region_tag   = rgn_tag[i];
                            r.device_addr  = it.addr & rgn_omask[i];
                            r.data_out     = r.is_write ? it.wdata : '0;
                        end
                    end
                end
            endcase
            return r;
        endfunction

        // Called at the clock edge on which an operation is transferred.
        function void note_item(t_item it);
            owed_results.push_back(decode_item(it));
        endfunction

        // Called at the clock edge on which a result is transferred.
        function void check_result(t_result got);
            t_result want;
            result_count++;
            if (owed_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("result %0d arrived with no operation owed: status=%0d",
                             result_count, got.status);
                end
                return;
            end
            want = owed_results.pop_front();
            if (got.status != want.status || got.region_index != want.region_index ||
                got.region_tag != want.region_tag || got.device_addr != want.device_addr ||
                got.is_write != want.is_write || got.data_out != want.data_out) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("result %0d mismatch", result_count);
                    $display("  expected: status=%0d index=%0d tag=%0d daddr=%h wr=%0b data=%h",
                             want.status, want.region_index, want.region_tag,
                             want.device_addr, want.is_write, want.data_out);
                    $display("  actual:   status=%0d index=%0d tag=%0d daddr=%h wr=%0b data=%h",
                             got.status, got.region_index, got.region_tag,
                             got.device_addr, got.is_write, got.data_out);
                end
            end
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    int unsigned     snd_idle_pct;
    int unsigned     rcv_idle_pct;
    int unsigned     cycle_count;
    decode_scoreboard sb;

    rtad_in_if  in_ch ();
    rtad_out_if out_ch ();

    region_table_address_decoder #(
        .REGION_COUNT(NUM_REGIONS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
    end
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** region_table_address_decoder: FAILED **");
            $finish;
        end
    end

    // The result side stalls at random according to the current phase.
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Every result transfer is checked against the oldest owed result.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.status       = t_status'(out_ch.status);
            got.region_index = out_ch.region_index;
            got.region_tag   = out_ch.region_tag;
            got.device_addr  = out_ch.device_addr;
            got.is_write     = out_ch.is_write;
            got.data_out     = out_ch.data_out;
            sb.check_result(got);
        end
    end

    function automatic t_item make_add(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi,
                                       logic [ADDR_W-1:0] rmask, logic [ADDR_W-1:0] omask,
                                       logic [TAG_W-1:0] tag);
        t_item it;
        it        = '0;
        it.op     = OP_ADD;
        it.rgn_lo = lo;
        it.rgn_hi = hi;
        it.rmask  = rmask;
        it.omask  = omask;
        it.tag    = tag;
        return it;
    endfunction

    function automatic t_item make_access(t_opcode op, logic [ADDR_W-1:0] addr,
                                          logic [BYTES_W-1:0] nbytes,
                                          logic [DATA_W-1:0] wdata);
        t_item it;
        it        = '0;
        it.op     = op;
        it.addr   = addr;
        it.nbytes = nbytes;
        it.wdata  = wdata;
        return it;
    endfunction

    // Random operation. Most accesses are aimed inside or across the edge of a
    // stored region so that hits at every index are common; the rest, and all
    // unused fields, are plain noise.
    function automatic t_item random_item();
        t_item             it;
        int unsigned       pick;
        int unsigned       idx;
        logic [ADDR_W-1:0] span;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W:0]   offset;
        it.addr   = $urandom;
        it.nbytes = BYTES_W'($urandom);
        it.wdata  = {$urandom, $urandom};
        it.rgn_lo = $urandom;
        it.rgn_hi = $urandom;
        it.rmask  = $urandom;
        it.omask  = $urandom;
        it.tag    = TAG_W'($urandom);
        pick      = $urandom_range(99);
        if (pick < 2) begin
            it.op = OP_CLEAR;
        end else if (pick < 22) begin
            it.op = OP_ADD;
            pick  = $urandom_range(9);
            if (pick < 7) begin
                it.rmask = '1;
            end else if (pick < 8) begin
                it.rmask = '1 >> $urandom_range(31);
            end
            if ($urandom_range(3) == 0) begin
                it.rgn_hi = it.rgn_lo + ADDR_W'($urandom);
            end else begin
                it.rgn_hi = it.rgn_lo + ADDR_W'($urandom_range(65535));
            end
            it.rgn_lo = it.rgn_lo & it.rmask;
            it.rgn_hi = it.rgn_hi & it.rmask;
            pick      = $urandom_range(3);
            if (pick == 0) begin
                it.omask = '1;
            end else if (pick == 1) begin
                it.omask = '1 >> $urandom_range(31);
            end
        end else begin
            it.op = (pick < 61) ? OP_READ : OP_WRITE;
            if (sb.rgn_used > 0 && $urandom_range(3) != 0) begin
                idx    = $urandom_range(sb.rgn_used - 1);
                span   = (sb.rgn_hi[idx] >= sb.rgn_lo[idx]) ?
                         sb.rgn_hi[idx] - sb.rgn_lo[idx] : '0;
                offset = {1'b0, $urandom} % ({1'b0, span} + 1);
                base   = sb.rgn_lo[idx] + offset[ADDR_W-1:0];
                if ($urandom_range(4) == 0) begin
                    base = sb.rgn_hi[idx] - ADDR_W'($urandom_range(7));
                end
                it.addr = (it.addr & ~sb.rgn_rmask[idx]) | (base & sb.rgn_rmask[idx]);
            end
            if ($urandom_range(9) != 0) begin
                it.nbytes = BYTES_W'(1 << $urandom_range(3));
            end
        end
        return it;
    endfunction

    // Offers one operation, with random idle cycles first, and returns on the
    // falling edge after its transfer.
    task automatic send_item(input t_item it);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.opcode          <= it.op;
        in_ch.access_addr     <= it.addr;
        in_ch.access_bytes    <= it.nbytes;
        in_ch.write_data      <= it.wdata;
        in_ch.new_first       <= it.rgn_lo;
        in_ch.new_last        <= it.rgn_hi;
        in_ch.new_range_mask  <= it.rmask;
        in_ch.new_offset_mask <= it.omask;
        in_ch.new_tag         <= it.tag;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        sb.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int unsigned count);
        for (int unsigned n = 0; n < count; n++) begin
            send_item(random_item());
        end
    endtask

    initial begin
        sb                    = new();
        cycle_count           = 0;
        snd_idle_pct          = 33;
        rcv_idle_pct          = 69;
        i_rst_n               = 1'b0;
        out_ch.ready          = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.opcode          = OP_CLEAR;
        in_ch.access_addr     = '0;
        in_ch.access_bytes    = '0;
        in_ch.write_data      = '0;
        in_ch.new_first       = '0;
        in_ch.new_last        = '0;
        in_ch.new_range_mask  = '0;
        in_ch.new_offset_mask = '0;
        in_ch.new_tag         = '0;

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty table: a clear, then a write that can only miss.
        send_item(make_access(OP_CLEAR, '0, '0, '0));
        send_item(make_access(OP_WRITE, '1, 4'd8, '1));

        // One plain region: hits at both ends, a straddle past the end, and a
        // zero-size access whose last byte falls below the start.
        send_item(make_add(32'h0000_1000, 32'h0000_1FFF, '1, 32'h0000_0FFF, '1));
        send_item(make_access(OP_READ, 32'h0000_1000, 4'd1, '1));
        send_item(make_access(OP_WRITE, 32'h0000_1FF8, 4'd8, '1));
        send_item(make_access(OP_READ, 32'h0000_1FFD, 4'd4, '0));
        send_item(make_access(OP_READ, 32'h0000_1000, 4'd0, '0));

        // A region with a zero range mask catches whatever the first one misses;
        // an access that wraps past the top of the address space still hits
        // the first region, since its last byte wraps to zero.
        send_item(make_add('0, '0, '0, '1, '0));
        send_item(make_access(OP_WRITE, '1, 4'd2, 64'h0123_4567_89AB_CDEF));
        send_item(make_access(OP_READ, '0, 4'd1, '0));

        // Fill the table, overflow it once, then clear it with every entry used.
        for (int unsigned n = 2; n < NUM_REGIONS; n++) begin
            send_item(make_add(ADDR_W'(n) << 28, (ADDR_W'(n) << 28) | 32'h0FFF_FFFF,
                               '1, '1 >> n, TAG_W'(n)));
        end
        send_item(make_add('1, '1, '1, '1, '1));
        send_item(make_access(OP_CLEAR, '0, '0, '0));

        // Random traffic under three idle patterns.
        send_random(PHASE_ITEMS);
        snd_idle_pct = 69;
        rcv_idle_pct = 33;
        send_random(PHASE_ITEMS);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        send_random(PHASE_ITEMS);
        in_ch.valid <= 1'b0;

        // Drain the owed results, then watch for stray ones.
        while (sb.owed_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (NUM_REGIONS + 8) @(posedge i_clk);

        if (sb.error_count == 0 && sb.owed_results.size() == 0) begin
            $display("** region_table_address_decoder: PASSED **");
        end else begin
            $display("** region_table_address_decoder: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
